// ===== rtl/stq_pkg.sv =====
// Shared types and constants of the sorted timer queue.
package stq_pkg;

  localparam int unsigned SlotCount = 16;
  localparam int unsigned TimeWidth = 48;
  localparam int unsigned SlotW = 4;
  localparam int unsigned IdxW = $clog2(SlotCount);
  localparam int unsigned LenW = $clog2(SlotCount + 1);
  localparam int unsigned FifoDepth = 2;
  localparam logic [TimeWidth-1:0] TimeMax = {TimeWidth{1'b1}};
  localparam logic [31:0] PeriodReset = 32'd1000;

  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpAdd  = 2'd1,
    OpDel  = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KindAdd      = 3'd0,
    KindDel      = 3'd1,
    KindExpired  = 3'd2,
    KindPeriodic = 3'd3,
    KindTick     = 3'd4
  } kind_e;

  typedef enum logic [0:0] {
    CfgEnable = 1'b0,
    CfgPeriod = 1'b1
  } cfg_e;

  // One classified command handed from the front to the back.
  typedef struct packed {
    op_e                  op;
    logic                 slot_ok;
    logic [SlotW-1:0]     slot;
    logic [TimeWidth-1:0] tval;
    logic [63:0]          data;
    logic [7:0]           handler;
  } cmd_t;

  typedef enum logic [2:0] {
    StIdle,
    StUnlink,
    StFind,
    StInsert,
    StPop,
    StPopOut,
    StTickEnd
  } state_e;

endpackage

// ===== rtl/sorted_timer_queue.sv =====
// Top level of the sorted timer queue.
// Channel  | Handshake              | Beat
// command  | start_i / busy_o       | operation, slot, expiry, data, handler, now
// config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// result   | result_valid_o         | kind, slot, data, handler, was_pending, last
// Between acceptance and its last result, an add runs an unlink walk, then an
// ordered search walk over the list; a delete runs the unlink walk only; a tick pops
// each expired timer in turn. Any command may also wait behind an earlier command.
// The back end's list walk steps one entry a cycle.
// Reset is asynchronous; the queue comes up empty. A two-entry command queue lets
// busy_o stay low while the back end works. Results cannot be stalled.
module sorted_timer_queue
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  timer_slot_i,
  input  logic [47:0] expiry_time_i,
  input  logic [63:0] callback_data_i,
  input  logic [7:0]  handler_id_i,
  input  logic [47:0] now_time_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [3:0]  slot_out_o,
  output logic [63:0] data_out_o,
  output logic [7:0]  handler_out_o,
  output logic        was_pending_o,
  output logic        last_o
);

  logic cmd_valid, cmd_take, back_busy;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  stq_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .timer_slot_i,
    .expiry_time_i, .callback_data_i, .handler_id_i, .now_time_i,
    .back_busy_i(back_busy), .cmd_valid_o(cmd_valid), .cmd_o(cmd),
    .cmd_take_i(cmd_take)
  );

  stq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .back_busy_o(back_busy), .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i),
    .cfg_data_i, .res_valid_o(result_valid_o), .kind_o, .slot_out_o,
    .data_out_o, .handler_out_o, .was_pending_o, .last_o
  );

endmodule

// ===== rtl/stq_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
module stq_front
  import stq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           operation_i,
  input  logic [3:0]           timer_slot_i,
  input  logic [47:0]          expiry_time_i,
  input  logic [63:0]          callback_data_i,
  input  logic [7:0]           handler_id_i,
  input  logic [47:0]          now_time_i,
  input  logic                 back_busy_i,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  logic                 cmd_take_i
);

  cmd_t            mem_q [FifoDepth];
  logic            wptr_q, rptr_q;
  logic [1:0]      cnt_q;
  logic            push;
  cmd_t            c;

  // Operation code 3 is dropped here and never reaches the back end.
  assign push   = start_i && !busy_o && (operation_i != OpNone);
  assign busy_o = (cnt_q == 2'(FifoDepth));

  always_comb begin
    c.op      = op_e'(operation_i);
    c.slot    = timer_slot_i;
    c.slot_ok = ({28'd0, timer_slot_i} < 32'(SlotCount));
    c.tval    = (operation_i == OpTick) ? now_time_i : expiry_time_i;
    c.data    = callback_data_i;
    c.handler = handler_id_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (cmd_take_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_take_i);
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rptr_q];

`ifndef ASSERT_OFF
  a_no_take_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_i |-> cmd_valid_o) else $error("take from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(FifoDepth)) else $error("queue count overflow");
  a_busy_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o && !back_busy_i |-> cmd_take_i) else $error("idle back end missed command");
`endif

endmodule

// ===== rtl/stq_back.sv =====
// Back end: sorted order list, slot store, tick scan and periodic event.
module stq_back
  import stq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_take_o,
  output logic              back_busy_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output logic              res_valid_o,
  output logic [2:0]        kind_o,
  output logic [3:0]        slot_out_o,
  output logic [63:0]       data_out_o,
  output logic [7:0]        handler_out_o,
  output logic              was_pending_o,
  output logic              last_o
);

  logic [TimeWidth-1:0] exp_q [SlotCount];
  logic [63:0]          dat_q [SlotCount];
  logic [7:0]           hdl_q [SlotCount];
  logic [SlotCount-1:0] pend_q;
  logic [IdxW-1:0]      ord_q [SlotCount];
  logic [LenW-1:0]      len_q;
  logic [TimeWidth-1:0] pnext_q;
  logic                 parmed_q, pen_q;
  logic [31:0]          pper_q;

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic   was_q;
  logic [LenW-1:0] pos_q, pos_d;
  logic   popped_q, popped_d;

  logic   r_valid_q, r_valid_d;
  logic [2:0] r_kind_q, r_kind_d;
  logic [3:0] r_slot_q, r_slot_d;
  logic [63:0] r_data_q, r_data_d;
  logic [7:0] r_hdl_q, r_hdl_d;
  logic r_pend_q, r_pend_d, r_last_q, r_last_d;

  logic [IdxW-1:0] sidx, hidx, pidx;
  logic [TimeWidth-1:0] head_exp;
  logic [TimeWidth:0] psum;
  logic [TimeWidth-1:0] prearm;
  logic pfire, parm;

  assign sidx     = cmd_q.slot[IdxW-1:0];
  assign hidx     = ord_q[0];
  assign pidx     = pos_q[IdxW-1:0];
  assign head_exp = exp_q[hidx];
  assign psum     = {1'b0, cmd_q.tval} + {{(TimeWidth + 1 - 32){1'b0}}, pper_q};
  assign prearm   = psum[TimeWidth] ? TimeMax : psum[TimeWidth-1:0];
  assign parm     = pen_q && !parmed_q;
  assign pfire    = pen_q && parmed_q && (cmd_q.tval >= pnext_q);

  assign cmd_take_o  = (state_q == StIdle) && cmd_valid_i;
  assign back_busy_o = (state_q != StIdle);

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    popped_d  = popped_q;
    r_valid_d = 1'b0;
    r_kind_d  = KindTick;
    r_slot_d  = '0;
    r_data_d  = '0;
    r_hdl_d   = '0;
    r_pend_d  = 1'b0;
    r_last_d  = 1'b0;
    unique case (state_q)
      StIdle: if (cmd_valid_i) begin
        pos_d    = '0;
        popped_d = 1'b0;
        state_d  = (cmd_i.op == OpTick) ? StPop : StUnlink;
      end
      // Walks the list one entry a cycle to find the slot being removed.
      StUnlink: begin
        if (!cmd_q.slot_ok || !was_q || pos_q >= len_q) begin
          pos_d   = '0;
          state_d = (cmd_q.op == OpAdd && cmd_q.slot_ok) ? StFind : StInsert;
        end else if (ord_q[pidx] == sidx) begin
          pos_d   = '0;
          state_d = (cmd_q.op == OpAdd) ? StFind : StInsert;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      StFind: begin
        if (pos_q < len_q && exp_q[ord_q[pidx]] <= cmd_q.tval) pos_d = pos_q + 1'b1;
        else state_d = StInsert;
      end
      StInsert: begin
        r_valid_d = 1'b1;
        r_kind_d  = (cmd_q.op == OpAdd) ? KindAdd : KindDel;
        r_slot_d  = cmd_q.slot;
        r_pend_d  = was_q;
        r_last_d  = 1'b1;
        state_d   = StIdle;
      end
      // Pops the head while it is due; the first check needs strictly below now.
      StPop: begin
        if (len_q != '0 && (popped_q ? head_exp <= cmd_q.tval : head_exp < cmd_q.tval)) begin
          r_valid_d = 1'b1;
          r_kind_d  = KindExpired;
          r_slot_d  = SlotW'(hidx);
          r_data_d  = dat_q[hidx];
          r_hdl_d   = hdl_q[hidx];
          popped_d  = 1'b1;
          state_d   = StPopOut;
        end else begin
          state_d = StTickEnd;
          if (pfire) r_valid_d = 1'b1;
          r_kind_d = KindPeriodic;
        end
      end
      StPopOut: state_d = StPop;
      StTickEnd: begin
        r_valid_d = 1'b1;
        r_kind_d  = KindTick;
        r_last_d  = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Shifts of the order list are done per entry with fixed neighbors.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      cmd_q <= cmd_i;
      was_q <= cmd_i.slot_ok && pend_q[cmd_i.slot[IdxW-1:0]];
    end
    if (state_q == StUnlink && cmd_q.slot_ok && was_q && pos_q < len_q &&
        ord_q[pidx] == sidx) begin
      for (int i = 0; i < SlotCount - 1; i++)
        if (LenW'(i) >= pos_q) ord_q[i] <= ord_q[i + 1];
    end
    if (state_q == StInsert && cmd_q.op == OpAdd && cmd_q.slot_ok) begin
      for (int i = 1; i < SlotCount; i++)
        if (LenW'(i) > pos_q) ord_q[i] <= ord_q[i - 1];
      ord_q[pidx] <= sidx;
      exp_q[sidx] <= cmd_q.tval;
      dat_q[sidx] <= cmd_q.data;
      hdl_q[sidx] <= cmd_q.handler;
    end
    if (state_q == StPop && state_d == StPopOut) begin
      for (int i = 0; i < SlotCount - 1; i++) ord_q[i] <= ord_q[i + 1];
    end
    pos_q    <= pos_d;
    popped_q <= popped_d;
    r_kind_q <= r_kind_d;
    r_slot_q <= r_slot_d;
    r_data_q <= r_data_d;
    r_hdl_q  <= r_hdl_d;
    r_pend_q <= r_pend_d;
    r_last_q <= r_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      r_valid_q <= 1'b0;
      pend_q    <= '0;
      len_q     <= '0;
      pnext_q   <= TimeMax;
      parmed_q  <= 1'b0;
      pen_q     <= 1'b0;
      pper_q    <= PeriodReset;
    end else begin
      state_q   <= state_d;
      r_valid_q <= r_valid_d;
      if (state_q == StUnlink && cmd_q.slot_ok && was_q && pos_q < len_q &&
          ord_q[pidx] == sidx) begin
        len_q        <= len_q - 1'b1;
        pend_q[sidx] <= 1'b0;
      end
      if (state_q == StInsert && cmd_q.op == OpAdd && cmd_q.slot_ok) begin
        len_q        <= len_q + 1'b1;
        pend_q[sidx] <= 1'b1;
      end
      if (state_q == StPop && state_d == StPopOut) begin
        len_q        <= len_q - 1'b1;
        pend_q[hidx] <= 1'b0;
      end
      if (state_q == StPop && state_d == StTickEnd) begin
        if (parm) parmed_q <= 1'b1;
        if (parm || pfire) pnext_q <= prearm;
      end
      if (cfg_we_i) begin
        unique case (cfg_e'(cfg_idx_i))
          CfgEnable: begin
            pen_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              parmed_q <= 1'b0;
              pnext_q  <= TimeMax;
            end
          end
          CfgPeriod: pper_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign res_valid_o   = r_valid_q;
  assign kind_o        = r_kind_q;
  assign slot_out_o    = r_slot_q;
  assign data_out_o    = r_data_q;
  assign handler_out_o = r_hdl_q;
  assign was_pending_o = r_pend_q;
  assign last_o        = r_last_q;

`ifndef ASSERT_OFF
  a_len_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(pend_q) == 32'(len_q)) else $error("length and pending bits disagree");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |-> state_q == StIdle) else $error("last result while busy");
  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StPopOut |=> state_q == StPop) else $error("pop sequencing");
`endif

endmodule
